>>> src/pif4_pkg.sv
// shared types and constants for the prime implicant finder
`timescale 1ns / 1ps
package pif4_pkg;

    // default number of function variables
    localparam int NUM_VARS_DEF = 4;
    // width of the on-set and don't-care minterm masks
    localparam int MINTERM_W    = 16;
    // width of the term value and care fields
    localparam int TERM_W       = 4;
    // most results listed for one function
    localparam int MAX_RESULTS  = 32;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // one result as held in the output register
    typedef struct packed {
        logic [TERM_W-1:0] value;
        logic [TERM_W-1:0] care;
        logic              valid;
        logic              last;
    } t_term;

endpackage

>>> src/pif4_in_if.sv
// input channel: one boolean function as on-set and don't-care masks
`timescale 1ns / 1ps
interface pif4_in_if;
    logic                           valid;
    logic                           ready;
    logic [pif4_pkg::MINTERM_W-1:0] on_set;
    logic [pif4_pkg::MINTERM_W-1:0] dont_care_set;

    modport source (output valid, output on_set, output dont_care_set, input ready);
    modport sink   (input valid, input on_set, input dont_care_set, output ready);
endinterface

>>> src/pif4_out_if.sv
// output channel: one prime implicant per transfer
`timescale 1ns / 1ps
interface pif4_out_if;
    logic                        valid;
    logic                        ready;
    logic [pif4_pkg::TERM_W-1:0] term_value;
    logic [pif4_pkg::TERM_W-1:0] term_care;
    logic                        term_valid;
    logic                        last_term;

    modport source (output valid, output term_value, output term_care,
                    output term_valid, output last_term, input ready);
    modport sink   (input valid, input term_value, input term_care,
                    input term_valid, input last_term, output ready);
endinterface

>>> src/prime_implicant_finder_4var.sv
// prime implicant finder: cube scan sequencer with a shared cube checker
//
// i_in carries one function per transfer: on_set and dont_care_set, one bit
// per minterm (on-set wins over don't-care, bits beyond 2^NUM_VARS ignored).
// o_out gives every prime implicant of on-set plus don't-care set that covers
// an on-set minterm, one per transfer, ordered by care mask then value, at
// most 32 of them; last_term marks the final one. With no prime implicant a
// single transfer with term_valid low and last_term high is sent.
// The sequencer walks all 3^NUM_VARS cubes (81 for four variables), one per
// cycle while the scan is not paused, through a single cube checker;
// i_in.ready is high only between items, so the block takes no new item
// before it is through with the last one. Each prime found waits in a
// one-entry holding register so that the final one can be marked; when the
// output register is still full and a further prime is found, the scan
// pauses until the receiver takes the waiting result. A result can wait in
// the output register while the next item is taken. Reset (synchronous,
// active low) returns to idle and empties the output register.
`timescale 1ns / 1ps
module prime_implicant_finder_4var #(
    parameter int NUM_VARS = pif4_pkg::NUM_VARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pif4_in_if.sink     i_in,
    pif4_out_if.source  o_out
);

    localparam int NMINT = 1 << NUM_VARS;
    localparam int CNT_W = $clog2(pif4_pkg::MAX_RESULTS + 1);
    localparam logic [NUM_VARS-1:0] VAR_ALL = '1;

    // minterm mask of the cube given by care and value
    function automatic logic [NMINT-1:0] f_cube(input logic [NUM_VARS-1:0] care,
                                                 input logic [NUM_VARS-1:0] value);
        logic [NMINT-1:0] mask;
        mask = '0;
        for (int m = 0; m < NMINT; m++) begin
            mask[m] = ((NUM_VARS'(m) & care) == value);
        end
        return mask;
    endfunction

    pif4_pkg::t_state        r_state, n_state;
    logic [NMINT-1:0]        r_on, n_on;
    logic [NMINT-1:0]        r_func, n_func;
    logic [NUM_VARS-1:0]     r_care, n_care;
    logic [NUM_VARS-1:0]     r_value, n_value;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_pend_valid, n_pend_valid;
    logic [NUM_VARS-1:0]     r_pend_care, n_pend_care;
    logic [NUM_VARS-1:0]     r_pend_value, n_pend_value;
    logic                    r_out_valid, n_out_valid;
    pif4_pkg::t_term         r_out, n_out;

    logic [NMINT-1:0]        w_cube;
    logic                    w_implicant;
    logic                    w_covers;
    logic                    w_reducible;
    logic                    w_prime;
    logic                    w_take;
    logic                    w_out_free;
    logic                    w_step;
    logic                    w_last_cube;

    // cube checker: implicant, covers an on-set minterm, no literal removable
    always_comb begin
        logic [NMINT-1:0]    sub_cube;
        logic [NUM_VARS-1:0] bit_mask;
        w_cube      = f_cube(r_care, r_value);
        w_implicant = ((w_cube & ~r_func) == '0);
        w_covers    = ((w_cube & r_on) != '0);
        w_reducible = 1'b0;
        for (int b = 0; b < NUM_VARS; b++) begin
            bit_mask = NUM_VARS'(1) << b;
            sub_cube = f_cube(r_care & ~bit_mask, r_value & ~bit_mask);
            if (r_care[b] && ((sub_cube & ~r_func) == '0)) begin
                w_reducible = 1'b1;
            end
        end
        w_prime = w_implicant && w_covers && !w_reducible;
    end

    assign w_take      = w_prime && (r_count < CNT_W'(pif4_pkg::MAX_RESULTS));
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_cube = (r_care == VAR_ALL) && (r_value == VAR_ALL);

    // sequencer: next state, cube walk, holding and output registers
    always_comb begin
        n_state      = r_state;
        n_on         = r_on;
        n_func       = r_func;
        n_care       = r_care;
        n_value      = r_value;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_care  = r_pend_care;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_step       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pif4_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_on         = i_in.on_set[NMINT-1:0];
                    n_func       = i_in.on_set[NMINT-1:0] | i_in.dont_care_set[NMINT-1:0];
                    n_care       = '0;
                    n_value      = '0;
                    n_count      = '0;
                    n_pend_valid = 1'b0;
                    n_state      = pif4_pkg::ST_SCAN;
                end
            end
            pif4_pkg::ST_SCAN: begin
                w_step = 1'b1;
                if (w_take) begin
                    if (r_pend_valid) begin
                        if (w_out_free) begin
                            // move the waiting prime on, hold the new one
                            n_out_valid = 1'b1;
                            n_out.value = pif4_pkg::TERM_W'(r_pend_value);
                            n_out.care  = pif4_pkg::TERM_W'(r_pend_care);
                            n_out.valid = 1'b1;
                            n_out.last  = 1'b0;
                        end else begin
                            w_step = 1'b0;
                        end
                    end
                    if (w_step) begin
                        n_pend_valid = 1'b1;
                        n_pend_care  = r_care;
                        n_pend_value = r_value;
                        n_count      = r_count + CNT_W'(1);
                    end
                end
                if (w_step) begin
                    if (w_last_cube) begin
                        n_state = pif4_pkg::ST_FLUSH;
                    end else if (r_value == r_care) begin
                        n_care  = r_care + NUM_VARS'(1);
                        n_value = '0;
                    end else begin
                        // next subset of the care mask in ascending order
                        n_value = ((r_value | ~r_care) + NUM_VARS'(1)) & r_care;
                    end
                end
            end
            pif4_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out.value = pif4_pkg::TERM_W'(r_pend_value);
                        n_out.care  = pif4_pkg::TERM_W'(r_pend_care);
                        n_out.valid = 1'b1;
                    end else begin
                        n_out.value = '0;
                        n_out.care  = '0;
                        n_out.valid = 1'b0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = pif4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pif4_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pif4_pkg::ST_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_on         <= n_on;
        r_func       <= n_func;
        r_care       <= n_care;
        r_value      <= n_value;
        r_pend_care  <= n_pend_care;
        r_pend_value <= n_pend_value;
        r_out        <= n_out;
    end

    // channel outputs
    assign i_in.ready       = (r_state == pif4_pkg::ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.term_value = r_out.value;
    assign o_out.term_care  = r_out.care;
    assign o_out.term_valid = r_out.valid;
    assign o_out.last_term  = r_out.last;

`ifndef SYNTHESIS
    // an empty answer is a single all-zero result that closes the item
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.valid) |-> (r_out.last && r_out.care == '0 && r_out.value == '0))
        else $error("empty result not marked last or not zero");

    // the cube walk never sets a value bit outside the care mask
    a_cube_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pif4_pkg::ST_SCAN) |-> ((r_value & ~r_care) == '0))
        else $error("cube value outside care mask");

    // an accepted item starts the scan from the first cube with no results
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=>
            (r_state == pif4_pkg::ST_SCAN && r_count == '0 && r_care == '0 && !r_pend_valid))
        else $error("scan did not start cleanly");

    // result count stays within the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(pif4_pkg::MAX_RESULTS))
        else $error("result count beyond limit");
`endif

endmodule

>>> test/prime_implicant_finder_4var_tb.sv
// testbench for the prime implicant finder: random handshakes, self-predicted term lists
`timescale 1ns / 1ps
module prime_implicant_finder_4var_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_FUNCS = 454;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int MINTERM_W    = pif4_pkg::MINTERM_W;
    localparam int TERM_W       = pif4_pkg::TERM_W;
    localparam int MAX_RESULTS  = pif4_pkg::MAX_RESULTS;

    // one boolean function as offered on the input channel
    typedef struct packed {
        logic [MINTERM_W-1:0] on_m;
        logic [MINTERM_W-1:0] dc_m;
    } t_func;

    logic i_clk;
    logic i_rst_n;

    pif4_in_if  in_ch ();
    pif4_out_if out_ch ();

    prime_implicant_finder_4var dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_func           pending_funcs[$];
    pif4_pkg::t_term prime_q[$];
    int              n_funcs;
    int              n_taken;
    int              n_errors;
    logic            in_xfer;
    int              hold_left;
    bit              hold_done;

    // clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // minterms covered by the cube with the given care mask and value
    function automatic logic [MINTERM_W-1:0] cube_span(logic [TERM_W-1:0] care,
                                                       logic [TERM_W-1:0] value);
        logic [MINTERM_W-1:0] span;
        span = '0;
        for (int m = 0; m < MINTERM_W; m++) begin
            if ((TERM_W'(m) & care) == value) span[m] = 1'b1;
        end
        return span;
    endfunction

    // list the prime implicants of one function in scan order into prime_q
    function automatic void list_primes(logic [MINTERM_W-1:0] on_m,
                                        logic [MINTERM_W-1:0] dc_m);
        logic [MINTERM_W-1:0] func;
        logic [MINTERM_W-1:0] span;
        logic [TERM_W-1:0]    cb;
        logic [TERM_W-1:0]    c4;
        logic [TERM_W-1:0]    v4;
        pif4_pkg::t_term      held;
        bit                   have_held;
        bit                   is_prime;
        int                   found;
        func      = on_m | dc_m;
        have_held = 1'b0;
        found     = 0;
        held      = '0;
        for (int c = 0; c < 16; c++) begin
            for (int v = 0; v < 16; v++) begin
                c4 = TERM_W'(c);
                v4 = TERM_W'(v);
                if ((v4 & ~c4) != '0) continue;
                span = cube_span(c4, v4);
                // must lie inside the function and touch the on-set
                if ((span & ~func) != '0 || (span & on_m) == '0) continue;
                is_prime = 1'b1;
                for (int b = 0; b < TERM_W; b++) begin
                    cb = TERM_W'(1 << b);
                    if ((c4 & cb) != '0 && (cube_span(c4 & ~cb, v4 & ~cb) & ~func) == '0)
                        is_prime = 1'b0;
                end
                if (!is_prime || found >= MAX_RESULTS) continue;
                // previous prime is known not to be the last one
                if (have_held) prime_q.push_back(held);
                held.value = v4;
                held.care  = c4;
                held.valid = 1'b1;
                held.last  = 1'b0;
                have_held  = 1'b1;
                found++;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            prime_q.push_back(held);
        end else begin
            held = '0;
            held.last = 1'b1;
            prime_q.push_back(held);
        end
    endfunction

    function automatic void check_field(string name, int unsigned expd, int unsigned act);
        if (expd != act) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, expd, act);
        end
    endfunction

    // 0: sender idles lightly, receiver heavily; 1: the reverse; 2: no idling
    function automatic int idle_phase();
        if (n_taken < n_funcs / 3) return 0;
        if (n_taken < (2 * n_funcs) / 3) return 1;
        return 2;
    endfunction

    // sampling at the rising edge: check results, then predict for a taken function
    always @(posedge i_clk) begin
        pif4_pkg::t_term got;
        pif4_pkg::t_term want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.value = out_ch.term_value;
            got.care  = out_ch.term_care;
            got.valid = out_ch.term_valid;
            got.last  = out_ch.last_term;
            if (prime_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none got %h", $time, got);
            end else begin
                want = prime_q.pop_front();
                check_field("term_value", 32'(want.value), 32'(got.value));
                check_field("term_care", 32'(want.care), 32'(got.care));
                check_field("term_valid", 32'(want.valid), 32'(got.valid));
                check_field("last_term", 32'(want.last), 32'(got.last));
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            list_primes(in_ch.on_set, in_ch.dont_care_set);
            n_taken++;
        end
        in_xfer <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // driver: offer the next pending function at the falling edge
    always @(negedge i_clk) begin
        t_func f;
        int    idle_pct;
        case (idle_phase())
            0:       idle_pct = 36;
            1:       idle_pct = 80;
            default: idle_pct = 0;
        endcase
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_xfer) begin
            if (pending_funcs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                f = pending_funcs.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.on_set        <= f.on_m;
                in_ch.dont_care_set <= f.dc_m;
            end else begin
                // idle: junk on the payload must be ignored
                in_ch.valid         <= 1'b0;
                in_ch.on_set        <= MINTERM_W'($urandom);
                in_ch.dont_care_set <= MINTERM_W'($urandom);
            end
        end
    end

    // receiver: random ready, with one long hold-off late in the run
    always @(negedge i_clk) begin
        int idle_pct;
        case (idle_phase())
            0:       idle_pct = 80;
            1:       idle_pct = 36;
            default: idle_pct = 0;
        endcase
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && n_taken >= (5 * n_funcs) / 6) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // run limit
    initial begin
        #12ms;
        $display("simulation failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        t_func f;
        t_func directed[$];
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.on_set        = '0;
        in_ch.dont_care_set = '0;
        out_ch.ready        = 1'b0;
        in_xfer             = 1'b0;
        hold_left           = 0;
        hold_done           = 1'b0;
        n_taken             = 0;
        n_errors            = 0;

        // empty on-set, only don't-cares, whole space, single minterms, overlaps
        directed = '{
            '{16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000},
            '{16'hFFFF, 16'hFFFF}, '{16'h0001, 16'h0000}, '{16'h8000, 16'h0000},
            '{16'h0001, 16'hFFFE}, '{16'h6996, 16'h0000}, '{16'h9669, 16'h0000},
            '{16'h7FFE, 16'h0000}, '{16'h8001, 16'h7FFE}, '{16'h00FF, 16'hFF00},
            '{16'hF0F0, 16'hFFFF}, '{16'h1248, 16'h0000}, '{16'hAAAA, 16'h5555},
            '{16'h0F0F, 16'h0F0F}, '{16'h8421, 16'h7BDE}, '{16'h6996, 16'h0660}
        };
        foreach (directed[i]) pending_funcs.push_back(directed[i]);

        // random functions across a spread of on-set and don't-care densities
        for (int i = 0; i < RANDOM_FUNCS; i++) begin
            case ($urandom_range(0, 4))
                0: begin
                    f.on_m = MINTERM_W'($urandom);
                    f.dc_m = MINTERM_W'($urandom);
                end
                1: begin
                    f.on_m = MINTERM_W'($urandom & $urandom);
                    f.dc_m = MINTERM_W'($urandom & $urandom & $urandom);
                end
                2: begin
                    f.on_m = MINTERM_W'($urandom | $urandom);
                    f.dc_m = MINTERM_W'($urandom & $urandom);
                end
                3: begin
                    f.on_m = MINTERM_W'($urandom & $urandom & $urandom);
                    f.dc_m = MINTERM_W'($urandom | $urandom);
                end
                default: begin
                    f.on_m = ($urandom_range(0, 3) == 0) ? '0
                           : MINTERM_W'(1 << $urandom_range(0, 15));
                    f.dc_m = MINTERM_W'($urandom);
                end
            endcase
            pending_funcs.push_back(f);
        end
        n_funcs = pending_funcs.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_taken == n_funcs && prime_q.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
